FILE: hw/rtl/int_to_pow2_base_ascii_defines.svh
// Assertion macros for the int_to_pow2_base_ascii block.
// No dependencies; expects clk and rst in the including scope.
`ifndef INT_TO_POW2_BASE_ASCII_DEFINES_SVH
`define INT_TO_POW2_BASE_ASCII_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2PA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2pa check failed");

// next-cycle implication, checked outside reset
`define I2PA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2pa check failed");

`endif

FILE: hw/rtl/i2pa_pkg.sv
// Shared types, constants and digit tables for int_to_pow2_base_ascii.
// No dependencies.
package i2pa_pkg;

  localparam int WORD_BITS      = 32;
  localparam int MAX_DIGIT_BITS = 5;
  localparam int DIGIT_W        = 5;
  // worst-case padded magnitude: 7 digits of 5 bits
  localparam int SR_W           = 35;
  localparam int CNT_W          = 5;
  localparam int ADDR_W         = 3;

  localparam logic [2:0] BITS_PER_DIGIT_RESET = 3'd4;
  localparam logic       REG_BITS_PER_DIGIT   = 1'b0;

  localparam logic [7:0] CHAR_MINUS   = 8'd45;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_A_MINUS_TEN = 8'd55;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_NONE    = 8'd0;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SIGN    = 5'b00010,
    S_DIGIT   = 5'b00100,
    S_NEWLINE = 5'b01000,
    S_ERROR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic [2:0] r;
  } step_ctrl_t;

  // digit count minus one for each legal width
  function automatic logic [CNT_W-1:0] last_digit_index(input logic [2:0] r);
    logic [CNT_W-1:0] n;
    unique case (r)
      3'd1:    n = 5'd31;
      3'd2:    n = 5'd15;
      3'd3:    n = 5'd10;
      3'd4:    n = 5'd7;
      3'd5:    n = 5'd6;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // leading zero bits that pad the top group to a full digit
  function automatic logic [1:0] pad_bits(input logic [2:0] r);
    logic [1:0] p;
    unique case (r)
      3'd3:    p = 2'd1;
      3'd5:    p = 2'd3;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < 5'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A_MINUS_TEN + {3'b000, d};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/i2pa_digit.sv
// Digit shifter: holds the padded magnitude and peels off the top
// r-bit digit each step. Depends on i2pa_pkg.
module i2pa_digit (
  input  logic                          clk,
  input  i2pa_pkg::step_ctrl_t          step,
  input  logic [i2pa_pkg::WORD_BITS-1:0] mag,
  output logic [i2pa_pkg::DIGIT_W-1:0]   digit
);

  logic [i2pa_pkg::SR_W-1:0] sr;
  logic [i2pa_pkg::SR_W-1:0] sr_next;
  logic [i2pa_pkg::SR_W-1:0] aligned;

  assign aligned = {mag, 3'b000};

  always_comb begin
    sr_next = sr;
    if (step.load) begin
      // right-justify so the top group gets its leading zeros
      unique case (i2pa_pkg::pad_bits(step.r))
        2'd1:    sr_next = aligned >> 1;
        2'd3:    sr_next = aligned >> 3;
        default: sr_next = aligned;
      endcase
    end else if (step.shift) begin
      unique case (step.r)
        3'd1:    sr_next = sr << 1;
        3'd2:    sr_next = sr << 2;
        3'd3:    sr_next = sr << 3;
        3'd4:    sr_next = sr << 4;
        3'd5:    sr_next = sr << 5;
        default: sr_next = sr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sr <= sr_next;
  end

  always_comb begin
    unique case (step.r)
      3'd1:    digit = {4'b0000, sr[34]};
      3'd2:    digit = {3'b000, sr[34:33]};
      3'd3:    digit = {2'b00, sr[34:32]};
      3'd4:    digit = {1'b0, sr[34:31]};
      3'd5:    digit = sr[34:30];
      default: digit = '0;
    endcase
  end

endmodule

FILE: hw/rtl/i2pa_seq.sv
// Sequencer: accepts a number, walks the digit shifter and drives the
// registered character output. Depends on i2pa_pkg and i2pa_digit.
module i2pa_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [2:0]                     bits_per_digit,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [i2pa_pkg::WORD_BITS-1:0] number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     char_code,
  output logic                           status,
  output logic                           last
);

  i2pa_pkg::state_t     state;
  i2pa_pkg::state_t     state_next;
  i2pa_pkg::step_ctrl_t step;
  logic [i2pa_pkg::CNT_W-1:0]   cnt;
  logic [i2pa_pkg::CNT_W-1:0]   cnt_next;
  logic                         started;
  logic                         started_next;
  logic [2:0]                   r_cur;
  logic [i2pa_pkg::WORD_BITS-1:0] mag;
  logic [i2pa_pkg::DIGIT_W-1:0]   digit;
  logic        r_ok;
  logic        room;
  logic        show;
  logic        accept;
  logic        load_out;
  logic [7:0]  o_char;
  logic        o_status;
  logic        o_last;

  assign in_stall = (state != i2pa_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign room     = !out_valid || !out_stall;
  assign r_ok     = (bits_per_digit != 3'd0) &&
                    (bits_per_digit <= 3'(i2pa_pkg::MAX_DIGIT_BITS));
  // two's complement negate; the most negative value stays 2^31
  assign mag      = number[31] ? (~number + 32'd1) : number;
  assign show     = (digit != '0) || started || (cnt == '0);

  i2pa_digit u_digit (
    .clk   (clk),
    .step  (step),
    .mag   (mag),
    .digit (digit)
  );

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    started_next = started;
    step.load    = 1'b0;
    step.shift   = 1'b0;
    step.r       = r_cur;
    load_out     = 1'b0;
    o_char       = i2pa_pkg::CHAR_NONE;
    o_status     = 1'b0;
    o_last       = 1'b0;
    unique case (state)
      i2pa_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!r_ok) begin
            state_next = i2pa_pkg::S_ERROR;
          end else begin
            step.load    = 1'b1;
            step.r       = bits_per_digit;
            cnt_next     = i2pa_pkg::last_digit_index(bits_per_digit);
            started_next = 1'b0;
            state_next   = number[31] ? i2pa_pkg::S_SIGN : i2pa_pkg::S_DIGIT;
          end
        end
      end
      i2pa_pkg::S_SIGN: begin
        if (room) begin
          load_out   = 1'b1;
          o_char     = i2pa_pkg::CHAR_MINUS;
          state_next = i2pa_pkg::S_DIGIT;
        end
      end
      i2pa_pkg::S_DIGIT: begin
        if (!show) begin
          // drop a leading zero digit without using the output
          step.shift = 1'b1;
          cnt_next   = cnt - 5'd1;
        end else if (room) begin
          load_out     = 1'b1;
          o_char       = i2pa_pkg::digit_char(digit);
          step.shift   = 1'b1;
          started_next = 1'b1;
          if (cnt == '0) begin
            state_next = i2pa_pkg::S_NEWLINE;
          end else begin
            cnt_next = cnt - 5'd1;
          end
        end
      end
      i2pa_pkg::S_NEWLINE: begin
        if (room) begin
          load_out   = 1'b1;
          o_char     = i2pa_pkg::CHAR_NEWLINE;
          o_last     = 1'b1;
          state_next = i2pa_pkg::S_IDLE;
        end
      end
      i2pa_pkg::S_ERROR: begin
        if (room) begin
          load_out   = 1'b1;
          o_char     = i2pa_pkg::CHAR_NONE;
          o_status   = 1'b1;
          o_last     = 1'b1;
          state_next = i2pa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = i2pa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= i2pa_pkg::S_IDLE;
      cnt       <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      started <= started_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cur <= bits_per_digit;
    end
    if (load_out) begin
      char_code <= o_char;
      status    <= o_status;
      last      <= o_last;
    end
  end

endmodule

FILE: hw/rtl/int_to_pow2_base_ascii.sv
// The first character ('-', error or leading digit) is registered after the number is accepted;
// a leading digit only once the suppressed leading zeros are shifted out.
// A number gives an optional '-', its digits and a newline (one error character for a bad
// width); in_stall stays high until the last is issued, so a new number waits for the old one.
// Output stall holds the sequencer; suppressed leading zeros are shifted out without using the output.
// Reset (synchronous, rst high) idles the sequencer, drops out_valid and sets r to 4.
module int_to_pow2_base_ascii (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [i2pa_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [i2pa_pkg::WORD_BITS-1:0] number,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            char_code,
  output logic                                  status,
  output logic                                  last
);

`include "int_to_pow2_base_ascii_defines.svh"

  logic [2:0] bits_per_digit;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == i2pa_pkg::REG_BITS_PER_DIGIT);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {29'd0, bits_per_digit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_digit <= i2pa_pkg::BITS_PER_DIGIT_RESET;
    end else if (wr_en) begin
      bits_per_digit <= pwdata[2:0];
    end
  end

  i2pa_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .bits_per_digit (bits_per_digit),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .number         (number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .char_code      (char_code),
    .status         (status),
    .last           (last)
  );

  `I2PA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `I2PA_ASSERT_NOW(a_error_form, out_valid && status, last && (char_code == 8'd0))
  `I2PA_ASSERT_NOW(a_mid_run_busy, out_valid && !last, in_stall)

endmodule
